// ===== rtl/bums_pkg.sv =====
// Package for the bottom-up merge sort block: sizes, controller states,
// and the command and status structs between controller and datapath.
// No dependencies.
package bums_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = ADDR_W + 1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_RUN,
        ST_READ,
        ST_WRITE,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;        // store input transfer
        logic sort_init;   // width := 1
        logic pass_start;  // lo := 0
        logic pass_end;    // width *= 2, swap banks
        logic run_start;   // set up a, b, o, mid, hi for one merge
        logic merge_wr;    // write one merged element
        logic emit_init;   // emit index := 0
        logic emit_next;   // advance emit index
        logic clear;       // end of set
    } cmd_t;

    typedef struct packed {
        logic pass_more;   // width < count
        logic run_more;    // lo < count
        logic run_end;     // this write finishes the merge
        logic emit_last;   // emit index is the final element
    } status_t;

endpackage

// ===== rtl/bottom_up_merge_sort.sv =====
// Loads up to 64 signed 32-bit values, one per transfer, until a transfer with
// s_tlast; further values are dropped and flag m_tuser. The set of n values is
// then merge sorted in ceil(log2 n) passes between two banks, each element of
// a pass taking a registered bank read, then a compare and write, and emitted
// in ascending order, each result after a registered bank read, the last one
// with m_tlast. No input is taken from the end of a set until its final result
// transfers. Depends on bums_pkg, bums_ctrl, bums_dp.
module bottom_up_merge_sort (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,   // last_result
    output logic        m_tuser    // [0] truncated
);
    import bums_pkg::*;

    cmd_t                         cmd;
    status_t                      st;
    logic signed [DATA_WIDTH-1:0] out_value;

    bums_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .st       (st),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    bums_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_value  (s_tdata[DATA_WIDTH-1:0]),
        .st        (st),
        .out_value (out_value),
        .out_trunc (m_tuser)
    );

    assign m_tdata = out_value;
    assign m_tlast = st.emit_last;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("load and emit overlap");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("no return to load after final result");

    a_keep_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tlast) |=> s_tready)
        else $error("load stopped before end of set");

    a_sort_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (!s_tready && !m_tvalid))
        else $error("sort did not start after end of set");

endmodule

// ===== rtl/bums_ctrl.sv =====
// Controller for the bottom-up merge sort block: load, merge passes, emit.
// Depends on bums_pkg.
module bums_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    input  logic              m_tready,
    input  bums_pkg::status_t st,
    output logic              s_tready,
    output logic              m_tvalid,
    output bums_pkg::cmd_t    cmd
);
    import bums_pkg::*;

    state_t state_reg, state_next;
    logic   s_xfer, m_xfer;

    assign s_xfer = s_tvalid && (state_reg == ST_LOAD);
    assign m_xfer = m_tready && (state_reg == ST_EMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_xfer && s_tlast) state_next = ST_PASS;
            end
            ST_PASS: begin
                state_next = st.pass_more ? ST_RUN : ST_EMIT_RD;
            end
            ST_RUN: begin
                state_next = st.run_more ? ST_READ : ST_PASS;
            end
            ST_READ: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                state_next = st.run_end ? ST_RUN : ST_READ;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_xfer) state_next = st.emit_last ? ST_LOAD : ST_EMIT_RD;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready      = 1'b1;
                cmd.load      = s_xfer;
                cmd.sort_init = s_xfer && s_tlast;
            end
            ST_PASS: begin
                cmd.pass_start = st.pass_more;
                cmd.emit_init  = !st.pass_more;
            end
            ST_RUN: begin
                cmd.run_start = st.run_more;
                cmd.pass_end  = !st.run_more;
            end
            ST_WRITE: begin
                cmd.merge_wr = 1'b1;
            end
            ST_EMIT: begin
                m_tvalid      = 1'b1;
                cmd.emit_next = m_xfer;
                cmd.clear     = m_xfer && st.emit_last;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/bums_dp.sv =====
// Datapath for the bottom-up merge sort block: two ping-pong element banks,
// run and index counters, signed compare. Depends on bums_pkg.
module bums_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bums_pkg::cmd_t                       cmd,
    input  logic signed [bums_pkg::DATA_WIDTH-1:0] in_value,
    output bums_pkg::status_t                    st,
    output logic signed [bums_pkg::DATA_WIDTH-1:0] out_value,
    output logic                                 out_trunc
);
    import bums_pkg::*;

    logic [DATA_WIDTH-1:0] mem0 [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] mem1 [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] rd0a_reg, rd0b_reg, rd1a_reg, rd1b_reg;

    logic [CNT_W-1:0] cnt_reg, width_reg, a_reg, b_reg, o_reg, mid_reg, hi_reg;
    logic [CNT_W:0]   lo_reg;
    logic             ovf_reg, bank_reg;

    logic [DATA_WIDTH-1:0] rd_a, rd_b, wr_data;
    logic [CNT_W:0]        lo_w, lo_2w, cnt_x;
    logic                  take_a, wr0, wr1;

    assign rd_a  = bank_reg ? rd1a_reg : rd0a_reg;
    assign rd_b  = bank_reg ? rd1b_reg : rd0b_reg;
    assign cnt_x = {1'b0, cnt_reg};
    assign lo_w  = lo_reg + {1'b0, width_reg};
    assign lo_2w = lo_reg + {width_reg, 1'b0};

    assign take_a = (a_reg < mid_reg) &&
                    ((b_reg >= hi_reg) || ($signed(rd_a) <= $signed(rd_b)));
    assign wr_data = cmd.load ? in_value : (take_a ? rd_a : rd_b);
    assign wr0 = (cmd.load && (cnt_reg < CNT_W'(MAX_ITEMS))) || (cmd.merge_wr && bank_reg);
    assign wr1 = cmd.merge_wr && !bank_reg;

    always_ff @(posedge aclk) begin
        if (wr0) mem0[cmd.load ? cnt_reg[ADDR_W-1:0] : o_reg[ADDR_W-1:0]] <= wr_data;
        if (wr1) mem1[o_reg[ADDR_W-1:0]] <= wr_data;
        rd0a_reg <= mem0[a_reg[ADDR_W-1:0]];
        rd0b_reg <= mem0[b_reg[ADDR_W-1:0]];
        rd1a_reg <= mem1[a_reg[ADDR_W-1:0]];
        rd1b_reg <= mem1[b_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            bank_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                if (cnt_reg < CNT_W'(MAX_ITEMS)) cnt_reg <= cnt_reg + 1'b1;
                else                             ovf_reg <= 1'b1;
            end
            if (cmd.pass_end) bank_reg <= !bank_reg;
            if (cmd.clear) begin
                cnt_reg  <= '0;
                ovf_reg  <= 1'b0;
                bank_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sort_init)  width_reg <= CNT_W'(1);
        if (cmd.pass_end)   width_reg <= {width_reg[CNT_W-2:0], 1'b0};
        if (cmd.pass_start) lo_reg <= '0;
        if (cmd.run_start) begin
            a_reg   <= lo_reg[CNT_W-1:0];
            o_reg   <= lo_reg[CNT_W-1:0];
            mid_reg <= (lo_w < cnt_x) ? lo_w[CNT_W-1:0] : cnt_reg;
            b_reg   <= (lo_w < cnt_x) ? lo_w[CNT_W-1:0] : cnt_reg;
            hi_reg  <= (lo_2w < cnt_x) ? lo_2w[CNT_W-1:0] : cnt_reg;
        end
        if (cmd.merge_wr) begin
            o_reg <= o_reg + 1'b1;
            if (take_a) a_reg <= a_reg + 1'b1;
            else        b_reg <= b_reg + 1'b1;
            if (st.run_end) lo_reg <= lo_2w;
        end
        if (cmd.emit_init) a_reg <= '0;
        if (cmd.emit_next) a_reg <= a_reg + 1'b1;
    end

    assign st.pass_more = width_reg < cnt_reg;
    assign st.run_more  = lo_reg < cnt_x;
    assign st.run_end   = (o_reg + 1'b1) == hi_reg;
    assign st.emit_last = (a_reg + 1'b1) == cnt_reg;

    assign out_value = rd_a;
    assign out_trunc = ovf_reg;

endmodule
